>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at each rising clock edge, quiet while reset is high.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check a property at each rising clock edge, reset included.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

>>> rtl/core/hpack_pkg.sv
// Types, codes and widths of the header block parser.
package hpack_pkg;

   // Integer decoder width; valid range 16 to 64
   localparam int INT_BITS  = 32;
   localparam int SHIFT_W   = $clog2(INT_BITS + 7);
   localparam int FV_W      = 32;
   localparam int CMP_W     = (INT_BITS > FV_W) ? INT_BITS : FV_W;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 32;
   localparam int RSP_TDATA_W = 40;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_MAX_TABLE_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SIZE_UPD_REQ   = 2'd1;

   localparam logic [31:0] MAX_TABLE_RESET = 32'd4096;

   // Representation octet masks
   localparam logic [7:0] B_TYPE_MASK   = 8'hE0;
   localparam logic [7:0] B_SIZE_UPDATE = 8'h20;

   typedef enum logic [5:0] {
      PH_REP   = 6'b000001,
      PH_INT   = 6'b000010,
      PH_NLEN  = 6'b000100,
      PH_NAME  = 6'b001000,
      PH_VLEN  = 6'b010000,
      PH_VALUE = 6'b100000
   } phase_type;

   typedef enum logic [2:0] {
      PU_FIELD   = 3'd0,
      PU_NAMEIDX = 3'd1,
      PU_NAMELEN = 3'd2,
      PU_VALLEN  = 3'd3,
      PU_SIZE    = 3'd4
   } purpose_type;

   typedef enum logic [2:0] {
      EV_INDEXED    = 3'd0,
      EV_NAME_INDEX = 3'd1,
      EV_NAME_START = 3'd2,
      EV_NAME_BYTE  = 3'd3,
      EV_VALUE_START = 3'd4,
      EV_VALUE_BYTE = 3'd5,
      EV_SIZE_UPDATE = 3'd6,
      EV_ERROR      = 3'd7
   } event_type;

   typedef enum logic [2:0] {
      ERR_NONE       = 3'd0,
      ERR_MISSING_UPD = 3'd1,
      ERR_OVERFLOW   = 3'd2,
      ERR_SIZE_LARGE = 3'd3,
      ERR_TRUNCATED  = 3'd4
   } err_type;

   typedef enum logic [1:0] {
      MODE_INCR    = 2'd0,
      MODE_WITHOUT = 2'd1,
      MODE_NEVER   = 2'd2
   } mode_type;

   // One result word
   typedef struct packed {
      event_type       ev;
      logic [FV_W-1:0] val;
      logic            huf;
      mode_type        mode;
      logic            last;
      err_type         code;
   } rsp_type;

endpackage

>>> rtl/core/hpack_header_block_parser.sv
// HPACK header block tokenizer: representations, prefixed integers, strings.
//
//  channel  dir  handshake            payload
//  req      in   req_tvalid/tready    tdata data_byte, tlast block_end
//  rsp      out  rsp_tvalid/tready    tuser event, tdata value/flags, tlast last byte
//  csr      in   csr_valid/csr_ready  csr_index, csr_wdata
//
// One octet is accepted per cycle; its token appears in the result register
// on the next cycle. The result register alone sets the rate: the next octet
// is taken whenever that register is empty or being drained. The csr channel
// is always ready. Reset is synchronous and returns the parser to expect a
// representation octet with max_table_size at 4096.
`include "assert_macros.svh"

module hpack_header_block_parser (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: [7:0] data_byte
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,
   input  logic                                req_tlast,
   // rsp_tdata: [31:0] field_value, [32] huffman, [34:33] indexing_mode,
   //            [37:35] error_code, [39:38] zero
   // rsp_tuser: [2:0] event_res
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [hpack_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic [2:0]                          rsp_tuser,
   output logic                                rsp_tlast,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [hpack_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [hpack_pkg::CSR_DAT_W-1:0]     csr_wdata
);

   localparam int IB = hpack_pkg::INT_BITS;
   localparam int SW = hpack_pkg::SHIFT_W;

   hpack_pkg::phase_type   phase_ff, phase_in;
   hpack_pkg::purpose_type purpose_ff, purpose_in;
   hpack_pkg::mode_type    mode_ff, mode_in;
   logic [IB-1:0]          accum_ff, accum_in;
   logic [SW-1:0]          shift_ff, shift_in;
   logic [IB-1:0]          rem_ff, rem_in;
   logic                   huf_ff, huf_in;
   logic                   pending_ff, pending_in;
   logic                   drop_ff, drop_in;
   logic [31:0]            max_size_ff;

   hpack_pkg::rsp_type     rsp_ff, res;
   logic                   rsp_valid_ff;
   logic                   has_res;
   logic                   err_raised;

   logic                   req_accept;
   logic [7:0]             b;

   // Helper requests raised in the phase decode
   logic                   beg;
   logic [6:0]             beg_pre;
   logic                   beg_full;
   hpack_pkg::purpose_type beg_pur;
   logic                   fin;
   logic [IB-1:0]          fin_val;
   hpack_pkg::purpose_type fin_pur;
   logic                   fail;
   hpack_pkg::err_type     fail_code;

   // Continuation arithmetic
   logic [IB+6:0]          cont_shifted;
   logic [IB:0]            cont_sum;
   logic [IB-1:0]          rem_dec;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign b          = req_tdata;

   assign cont_shifted = (IB + 7)'(b[6:0]) << shift_ff;
   assign cont_sum     = {1'b0, accum_ff} + {1'b0, cont_shifted[IB-1:0]};
   assign rem_dec      = rem_ff - IB'(1);

   // Decode one octet against the current phase
   always_comb begin
      phase_in   = phase_ff;
      purpose_in = purpose_ff;
      mode_in    = mode_ff;
      accum_in   = accum_ff;
      shift_in   = shift_ff;
      rem_in     = rem_ff;
      huf_in     = huf_ff;
      pending_in = pending_ff;
      drop_in    = drop_ff;
      has_res    = 1'b0;
      res        = '0;
      err_raised = 1'b0;
      beg        = 1'b0;
      beg_pre    = '0;
      beg_full   = 1'b0;
      beg_pur    = hpack_pkg::PU_FIELD;
      fin        = 1'b0;
      fin_val    = '0;
      fin_pur    = hpack_pkg::PU_FIELD;
      fail       = 1'b0;
      fail_code  = hpack_pkg::ERR_NONE;

      if (drop_ff) begin
         // discard octets up to block end
         if (req_tlast) begin
            drop_in  = 1'b0;
            phase_in = hpack_pkg::PH_REP;
         end
      end else begin
         unique case (phase_ff) inside
            hpack_pkg::PH_REP: begin
               if (pending_ff && ((b & hpack_pkg::B_TYPE_MASK) != hpack_pkg::B_SIZE_UPDATE)) begin
                  fail      = 1'b1;
                  fail_code = hpack_pkg::ERR_MISSING_UPD;
               end else if (b[7]) begin
                  if (b[6:0] == 7'd0) begin
                     fail      = 1'b1;
                     fail_code = hpack_pkg::ERR_NONE;
                  end else begin
                     beg      = 1'b1;
                     beg_pre  = b[6:0];
                     beg_full = &b[6:0];
                     beg_pur  = hpack_pkg::PU_FIELD;
                  end
               end else if (b[6]) begin
                  mode_in = hpack_pkg::MODE_INCR;
                  if (b[5:0] == 6'd0) begin
                     phase_in = hpack_pkg::PH_NLEN;
                  end else begin
                     beg      = 1'b1;
                     beg_pre  = {1'b0, b[5:0]};
                     beg_full = &b[5:0];
                     beg_pur  = hpack_pkg::PU_NAMEIDX;
                  end
               end else if (b[5]) begin
                  beg      = 1'b1;
                  beg_pre  = {2'b00, b[4:0]};
                  beg_full = &b[4:0];
                  beg_pur  = hpack_pkg::PU_SIZE;
               end else begin
                  mode_in = b[4] ? hpack_pkg::MODE_NEVER : hpack_pkg::MODE_WITHOUT;
                  if (b[3:0] == 4'd0) begin
                     phase_in = hpack_pkg::PH_NLEN;
                  end else begin
                     beg      = 1'b1;
                     beg_pre  = {3'b000, b[3:0]};
                     beg_full = &b[3:0];
                     beg_pur  = hpack_pkg::PU_NAMEIDX;
                  end
               end
            end
            hpack_pkg::PH_INT: begin
               // add one continuation octet, checking for overflow
               if (shift_ff >= SW'(IB)) begin
                  fail      = 1'b1;
                  fail_code = hpack_pkg::ERR_OVERFLOW;
               end else if ((cont_shifted >> IB) != '0 || cont_sum[IB]) begin
                  fail      = 1'b1;
                  fail_code = hpack_pkg::ERR_OVERFLOW;
               end else begin
                  accum_in = cont_sum[IB-1:0];
                  shift_in = shift_ff + SW'(7);
                  if (!b[7]) begin
                     fin     = 1'b1;
                     fin_val = cont_sum[IB-1:0];
                     fin_pur = purpose_ff;
                  end
               end
            end
            hpack_pkg::PH_NLEN: begin
               huf_in   = b[7];
               beg      = 1'b1;
               beg_pre  = b[6:0];
               beg_full = &b[6:0];
               beg_pur  = hpack_pkg::PU_NAMELEN;
            end
            hpack_pkg::PH_VLEN: begin
               huf_in   = b[7];
               beg      = 1'b1;
               beg_pre  = b[6:0];
               beg_full = &b[6:0];
               beg_pur  = hpack_pkg::PU_VALLEN;
            end
            hpack_pkg::PH_NAME, hpack_pkg::PH_VALUE: begin
               rem_in   = rem_dec;
               has_res  = 1'b1;
               res.ev   = (phase_ff == hpack_pkg::PH_NAME) ? hpack_pkg::EV_NAME_BYTE
                                                           : hpack_pkg::EV_VALUE_BYTE;
               res.val  = hpack_pkg::FV_W'(b);
               res.mode = mode_ff;
               res.last = (rem_dec == '0);
               if (rem_dec == '0) begin
                  phase_in = (phase_ff == hpack_pkg::PH_NAME) ? hpack_pkg::PH_VLEN
                                                              : hpack_pkg::PH_REP;
               end
            end
            default: begin
               phase_in = hpack_pkg::PH_REP;
            end
         endcase

         // start an integer: finish on a short prefix, else collect octets
         if (beg) begin
            if (!beg_full) begin
               fin     = 1'b1;
               fin_val = IB'(beg_pre);
               fin_pur = beg_pur;
            end else begin
               accum_in   = IB'(beg_pre);
               shift_in   = '0;
               purpose_in = beg_pur;
               phase_in   = hpack_pkg::PH_INT;
            end
         end

         // deliver a finished integer
         if (fin) begin
            has_res = 1'b1;
            res.val = hpack_pkg::FV_W'(fin_val);
            case (fin_pur)
               hpack_pkg::PU_FIELD: begin
                  res.ev   = hpack_pkg::EV_INDEXED;
                  phase_in = hpack_pkg::PH_REP;
               end
               hpack_pkg::PU_NAMEIDX: begin
                  res.ev   = hpack_pkg::EV_NAME_INDEX;
                  res.mode = mode_in;
                  phase_in = hpack_pkg::PH_VLEN;
               end
               hpack_pkg::PU_NAMELEN: begin
                  res.ev   = hpack_pkg::EV_NAME_START;
                  res.huf  = huf_in;
                  res.mode = mode_in;
                  rem_in   = fin_val;
                  phase_in = (fin_val != '0) ? hpack_pkg::PH_NAME : hpack_pkg::PH_VLEN;
               end
               hpack_pkg::PU_VALLEN: begin
                  res.ev   = hpack_pkg::EV_VALUE_START;
                  res.huf  = huf_in;
                  res.mode = mode_in;
                  rem_in   = fin_val;
                  phase_in = (fin_val != '0) ? hpack_pkg::PH_VALUE : hpack_pkg::PH_REP;
               end
               default: begin
                  if (hpack_pkg::CMP_W'(fin_val) > hpack_pkg::CMP_W'(max_size_ff)) begin
                     fail      = 1'b1;
                     fail_code = hpack_pkg::ERR_SIZE_LARGE;
                  end else begin
                     res.ev     = hpack_pkg::EV_SIZE_UPDATE;
                     pending_in = 1'b0;
                     phase_in   = hpack_pkg::PH_REP;
                  end
               end
            endcase
         end

         // raise an error and drop the rest of the block
         if (fail) begin
            err_raised = 1'b1;
            drop_in    = 1'b1;
            phase_in   = hpack_pkg::PH_REP;
            has_res    = 1'b1;
            res        = '0;
            res.ev     = hpack_pkg::EV_ERROR;
            res.code   = fail_code;
         end

         // block end: flag an unfinished representation, then rearm
         if (req_tlast) begin
            if (!err_raised && phase_in != hpack_pkg::PH_REP) begin
               has_res  = 1'b1;
               res      = '0;
               res.ev   = hpack_pkg::EV_ERROR;
               res.code = hpack_pkg::ERR_TRUNCATED;
            end
            drop_in  = 1'b0;
            phase_in = hpack_pkg::PH_REP;
         end
      end
   end

   // Parser state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= hpack_pkg::PH_REP;
         purpose_ff  <= hpack_pkg::PU_FIELD;
         mode_ff     <= hpack_pkg::MODE_INCR;
         accum_ff    <= '0;
         shift_ff    <= '0;
         rem_ff      <= '0;
         huf_ff      <= 1'b0;
         pending_ff  <= 1'b0;
         drop_ff     <= 1'b0;
         max_size_ff <= hpack_pkg::MAX_TABLE_RESET;
      end else begin
         if (req_accept) begin
            phase_ff   <= phase_in;
            purpose_ff <= purpose_in;
            mode_ff    <= mode_in;
            accum_ff   <= accum_in;
            shift_ff   <= shift_in;
            rem_ff     <= rem_in;
            huf_ff     <= huf_in;
            drop_ff    <= drop_in;
         end
         // load the update request from csr, else follow the parser
         if (csr_valid && csr_index == hpack_pkg::REG_SIZE_UPD_REQ) begin
            pending_ff <= csr_wdata[0];
         end else if (req_accept) begin
            pending_ff <= pending_in;
         end
         if (csr_valid && csr_index == hpack_pkg::REG_MAX_TABLE_SIZE) begin
            max_size_ff <= csr_wdata;
         end
      end
   end

   // Result register: load on a token, drain on rsp handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= has_res;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && has_res) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.ev;
   assign rsp_tlast  = rsp_ff.last;
   assign rsp_tdata  = {2'b00, rsp_ff.code, rsp_ff.mode, rsp_ff.huf, rsp_ff.val};

   `ASSERT_CLK_ALWAYS(a_drop_in_rep, drop_ff |-> (phase_ff == hpack_pkg::PH_REP), "dropping outside representation phase")
   `ASSERT_CLK(a_end_rearms, (req_accept && req_tlast) |=> (!drop_ff && phase_ff == hpack_pkg::PH_REP), "block end did not rearm parser")
   `ASSERT_CLK(a_err_drops, (req_accept && has_res && res.ev == hpack_pkg::EV_ERROR && !req_tlast) |=> drop_ff, "error without drop")
   `ASSERT_CLK_ALWAYS(a_string_len, (phase_ff == hpack_pkg::PH_NAME || phase_ff == hpack_pkg::PH_VALUE) |-> (rem_ff != '0), "string phase with no bytes left")

endmodule
